FILE: design/rilp_pkg.sv
// Shared types, constants and character helpers for the radix integer literal parser.
package rilp_pkg;

   localparam int CHAR_BITS          = 8;
   localparam int RSP_VALUE_BITS     = 64;
   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int RADIX_BITS         = 6;
   localparam int DIGIT_BITS         = 6;

   localparam logic [RADIX_BITS-1:0] RADIX_DEFAULT = RADIX_BITS'(10);
   localparam logic [DIGIT_BITS-1:0] NO_DIGIT      = DIGIT_BITS'(36);
   localparam logic [RADIX_BITS-1:0] NO_PREFIX     = '0;

   localparam logic [CHAR_BITS-1:0] CH_PLUS  = "+";
   localparam logic [CHAR_BITS-1:0] CH_MINUS = "-";
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = "0";

   typedef enum logic [1:0] {
      PH_SIGNS,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic                 last;
   } item_type;

   function automatic logic [CHAR_BITS-1:0] lower_case(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] r;
      r = c;
      if (c inside {["A":"Z"]}) begin
         r = c + CHAR_BITS'(32);
      end
      return r;
   endfunction

   // Expects a lower-case character.
   function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
      logic [DIGIT_BITS-1:0] d;
      logic [CHAR_BITS-1:0]  t;
      d = NO_DIGIT;
      t = '0;
      if (c inside {["0":"9"]}) begin
         t = c - CH_ZERO;
         d = t[DIGIT_BITS-1:0];
      end else if (c inside {["a":"z"]}) begin
         t = c - CHAR_BITS'("a") + CHAR_BITS'(10);
         d = t[DIGIT_BITS-1:0];
      end
      return d;
   endfunction

   function automatic logic [RADIX_BITS-1:0] prefix_radix(input logic [CHAR_BITS-1:0] c);
      logic [RADIX_BITS-1:0] r;
      case (c)
         "b":     r = RADIX_BITS'(2);
         "s":     r = RADIX_BITS'(6);
         "o":     r = RADIX_BITS'(8);
         "d":     r = RADIX_BITS'(10);
         "z":     r = RADIX_BITS'(12);
         "x":     r = RADIX_BITS'(16);
         "n":     r = RADIX_BITS'(36);
         default: r = NO_PREFIX;
      endcase
      return r;
   endfunction

endpackage

FILE: design/rilp_req_if.sv
// Character channel: one character of an atom per item, with a last flag.
interface rilp_req_if
   import rilp_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] ch;
   logic                 last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

FILE: design/rilp_rsp_if.sv
// Result channel: one parse result per atom.
interface rilp_rsp_if
   import rilp_pkg::*;
   ();
   logic                             valid;
   logic                             ready;
   logic                             is_number;
   logic signed [RSP_VALUE_BITS-1:0] value;

   modport source (output valid, output is_number, output value, input ready);
   modport sink   (input valid, input is_number, input value, output ready);
endinterface

FILE: design/radix_integer_literal_parser_unit.sv
// Radix integer literal parser: characters in, one signed value or failure flag per atom out.
//
// The req channel carries one character of an atom per item, with last set on its final
// character. Leading '+' and '-' signs set the sign, a "0" followed by b, s, o, d, z, x or n
// selects base 2, 6, 8, 10, 12, 16 or 36, and the rest are digits in that base.
// For each item with last set, the rsp channel delivers one item: is_number and the value,
// sign-extended to 64 bits from VALUE_BITS, or is_number low with a zero value.
// Items without last produce nothing on rsp.
// A character is captured in an input register, and then the parse state is updated
// (one multiply of the accumulator by the radix plus the digit) and the result register
// loaded; rsp valid is driven by the result register.
// One character is accepted every cycle, unless a final character waits on a pending result.
// When rsp is stalled with a result pending, the input register still takes characters that
// are not the end of an atom; a second final character waits in the input register, and req
// ready stays low until the pending result is taken.
// Synchronous reset clears both channels and returns the parse state to the sign phase.
module radix_integer_literal_parser_unit
   import rilp_pkg::*;
   #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
   )
   (
   input  logic        clock,
   input  logic        reset,
   rilp_req_if.sink    req_chan,
   rilp_rsp_if.source  rsp_chan
   );

   item_type item;
   logic     item_valid;
   logic     take;

   rilp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item       (item),
      .item_valid (item_valid)
   );

   rilp_parse_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_parse_core (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .take       (take),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: design/rilp_in_reg.sv
// Input register that captures one character item and holds it until the parser takes it.
module rilp_in_reg
   import rilp_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   rilp_req_if.sink    req_chan,
   input  logic        take,
   output item_type    item,
   output logic        item_valid
   );

   item_type item_ff, item_in;
   logic     valid_ff, valid_in;
   logic     load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (load) begin
         item_in.ch   = req_chan.ch;
         item_in.last = req_chan.last;
         valid_in     = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

FILE: design/rilp_parse_core.sv
// Parse state, per-character update and the result register.
module rilp_parse_core
   import rilp_pkg::*;
   #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
   )
   (
   input  logic        clock,
   input  logic        reset,
   input  item_type    item,
   input  logic        item_valid,
   output logic        take,
   rilp_rsp_if.source  rsp_chan
   );

   phase_type               phase_ff, phase_in;
   logic                    negative_ff, negative_in;
   logic [RADIX_BITS-1:0]   radix_ff, radix_in;
   logic [VALUE_BITS-1:0]   acc_ff, acc_in;
   logic                    failed_ff, failed_in;
   logic                    seen_ff, seen_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            is_number_ff, is_number_in;
   logic signed [RSP_VALUE_BITS-1:0] value_ff, value_in;

   logic [CHAR_BITS-1:0]           c;
   logic [DIGIT_BITS-1:0]          digit;
   logic [RADIX_BITS-1:0]          pre_radix;
   logic [RADIX_BITS-1:0]          use_radix;
   logic [VALUE_BITS+RADIX_BITS-1:0] product;
   logic [VALUE_BITS-1:0]          acc_step;
   logic                           digit_ok;

   // Next parse state before the end-of-atom reset.
   phase_type               ph_n;
   logic                    neg_n;
   logic [RADIX_BITS-1:0]   rad_n;
   logic [VALUE_BITS-1:0]   acc_n;
   logic                    fail_n;
   logic                    seen_n;

   logic                    ok;
   logic [VALUE_BITS-1:0]   mag;
   logic [VALUE_BITS-1:0]   signed_val;

   assign take = item_valid && (!item.last || !rsp_valid_ff || rsp_chan.ready);

   assign c         = lower_case(item.ch);
   assign digit     = digit_value(c);
   assign pre_radix = prefix_radix(c);

   // Digits before the prefix decision are always base ten.
   assign use_radix = (phase_ff == PH_DIGITS) ? radix_ff : RADIX_DEFAULT;
   assign product   = acc_ff * use_radix;
   assign acc_step  = product[VALUE_BITS-1:0] + VALUE_BITS'(digit);
   assign digit_ok  = {1'b0, digit} < {1'b0, use_radix};

   // Next-state logic.
   always_comb begin
      ph_n   = phase_ff;
      neg_n  = negative_ff;
      rad_n  = radix_ff;
      acc_n  = acc_ff;
      fail_n = failed_ff;
      seen_n = seen_ff;
      case (phase_ff)
         PH_SIGNS: begin
            if (c == CH_PLUS) begin
               ph_n = PH_SIGNS;
            end else if (c == CH_MINUS) begin
               neg_n = !negative_ff;
            end else if (c == CH_ZERO) begin
               ph_n = PH_ZERO;
            end else begin
               ph_n  = PH_DIGITS;
               rad_n = RADIX_DEFAULT;
               if (digit_ok) begin
                  acc_n  = acc_step;
                  seen_n = 1'b1;
               end else begin
                  fail_n = 1'b1;
               end
            end
         end
         PH_ZERO: begin
            ph_n = PH_DIGITS;
            if (pre_radix != NO_PREFIX) begin
               rad_n = pre_radix;
            end else begin
               // The leading zero was a digit; the accumulator is still zero.
               rad_n  = RADIX_DEFAULT;
               seen_n = 1'b1;
               if (digit_ok) begin
                  acc_n = acc_step;
               end else begin
                  fail_n = 1'b1;
               end
            end
         end
         PH_DIGITS: begin
            if (!failed_ff) begin
               if (digit_ok) begin
                  acc_n  = acc_step;
                  seen_n = 1'b1;
               end else begin
                  fail_n = 1'b1;
               end
            end
         end
         default: begin
            ph_n = PH_SIGNS;
         end
      endcase

      phase_in    = ph_n;
      negative_in = neg_n;
      radix_in    = rad_n;
      acc_in      = acc_n;
      failed_in   = fail_n;
      seen_in     = seen_n;
      if (take && item.last) begin
         phase_in    = PH_SIGNS;
         negative_in = 1'b0;
         radix_in    = RADIX_DEFAULT;
         acc_in      = '0;
         failed_in   = 1'b0;
         seen_in     = 1'b0;
      end else if (!take) begin
         phase_in    = phase_ff;
         negative_in = negative_ff;
         radix_in    = radix_ff;
         acc_in      = acc_ff;
         failed_in   = failed_ff;
         seen_in     = seen_ff;
      end
   end

   // Result logic.
   always_comb begin
      case (ph_n)
         PH_ZERO:   ok = 1'b1;
         PH_DIGITS: ok = !fail_n && seen_n;
         default:   ok = 1'b0;
      endcase
      mag        = (ph_n == PH_ZERO) ? '0 : acc_n;
      signed_val = neg_n ? (VALUE_BITS'(0) - mag) : mag;

      rsp_valid_in = rsp_valid_ff;
      is_number_in = is_number_ff;
      value_in     = value_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take && item.last) begin
         rsp_valid_in = 1'b1;
         is_number_in = ok;
         value_in     = ok ? RSP_VALUE_BITS'($signed(signed_val)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIGNS;
         negative_ff  <= 1'b0;
         radix_ff     <= RADIX_DEFAULT;
         acc_ff       <= '0;
         failed_ff    <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         radix_ff     <= radix_in;
         acc_ff       <= acc_in;
         failed_ff    <= failed_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_number_ff <= is_number_in;
      value_ff     <= value_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.is_number = is_number_ff;
   assign rsp_chan.value     = value_ff;

endmodule
